// ===== sv/mtes_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtes_pkg
// Shared codes, limits and controller/datapath interface types of the
// multi-timer expiry scheduler.
// ----------------------------------------------------------------------------
package mtes_pkg;

	localparam logic [3:0] OP_TICK    = 4'd0;
	localparam logic [3:0] OP_CREATE  = 4'd1;
	localparam logic [3:0] OP_DESTROY = 4'd2;
	localparam logic [3:0] OP_SET     = 4'd3;
	localparam logic [3:0] OP_SET_IVL = 4'd4;
	localparam logic [3:0] OP_SET_JIT = 4'd5;
	localparam logic [3:0] OP_RESTART = 4'd6;
	localparam logic [3:0] OP_STOP    = 4'd7;
	localparam logic [3:0] OP_QUERY   = 4'd8;

	localparam logic [1:0] KIND_EXPIRY   = 2'd0;
	localparam logic [1:0] KIND_DONE     = 2'd1;
	localparam logic [1:0] KIND_QUERY    = 2'd2;
	localparam logic [1:0] KIND_TICK_END = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_SLOT = 2'd1;
	localparam logic [1:0] ST_BIG_IVL  = 2'd2;
	localparam logic [1:0] ST_BIG_JIT  = 2'd3;

	localparam logic [31:0] BIG_LIMIT   = 32'd2147423647;
	localparam logic [31:0] SPLIT_LIMIT = 32'd21474836;
	localparam logic [31:0] JIT_SCALE   = 32'd100;
	localparam logic [31:0] JIT_PCT_MAX = 32'd99;
	localparam logic [5:0]  MAX_FIRES   = 6'd32;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_LATCH,
		DP_TICK_ADD,
		DP_HEAD,
		DP_RM_START,
		DP_RM_STEP,
		DP_JIT_START,
		DP_JIT_WB,
		DP_EXP_NOW,
		DP_EXP_ADD,
		DP_LATE_DIV,
		DP_MISS_MUL,
		DP_MISS_WB,
		DP_INS_START,
		DP_INS_STEP,
		DP_RUN_CLR,
		DP_FIRE,
		DP_CREATE,
		DP_CLEAR,
		DP_JMUL,
		DP_JDIV,
		DP_JWB,
		DP_EMIT
	} dp_op_t;

	typedef enum logic [1:0] {
		XS_SLOT,
		XS_HEAD,
		XS_SCAN
	} xsel_t;

	typedef struct packed {
		dp_op_t     op;
		xsel_t      xsel;
		logic [1:0] kind;
		logic [1:0] status;
		logic       full;
		logic       last;
	} dp_cmd_t;

	typedef struct packed {
		logic [3:0] op;
		logic       id_ok;
		logic       id_free;
		logic       run;
		logic       cont;
		logic       val_big;
		logic       pct_big;
		logic       jit_on;
		logic       late_pos;
		logic       scan_hit;
		logic       scan_end;
		logic       ins_stop;
		logic       q_full;
		logic       head_due;
		logic       div_busy;
		logic       out_free;
	} dp_stat_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DEC,
		S_T_CHK,
		S_RM_START,
		S_RM,
		S_JIT,
		S_JIT_WAIT,
		S_EXP_NOW,
		S_EXP_ADD,
		S_LATE,
		S_LATE_WAIT,
		S_MISS_WB,
		S_INS_START,
		S_INS,
		S_RUN_CLR,
		S_FIRE,
		S_CLEAR,
		S_JDIV,
		S_JWAIT,
		S_EMIT_CMD,
		S_EMIT_BAD,
		S_EMIT_EXP,
		S_EMIT_END
	} state_t;

endpackage

// ===== sv/mtes_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtes_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mtes_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [31:0] quot,
	output logic [31:0] rem
);

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [31:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [32:0] trial;
	logic [32:0] diff;
	logic        ge;

	assign trial = {rem_q, quo_q[31]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = !diff[32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : trial[31:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

// ===== sv/mtes_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtes_dp
// Timer bank, sorted expiry queue, working registers and result register.
// ----------------------------------------------------------------------------
module mtes_dp import mtes_pkg::*; #(
	parameter int NUM_TIMERS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	input  logic [3:0]  in_op,
	input  logic [3:0]  in_id,
	input  logic [31:0] in_value,
	input  logic        in_periodic,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_kind,
	output logic [3:0]  out_slot,
	output logic [1:0]  out_status,
	output logic        out_running,
	output logic [31:0] out_interval,
	output logic [31:0] out_due,
	output logic [31:0] out_invoked,
	output logic [31:0] out_missed,
	output logic        out_last
);

	localparam int IW = $clog2(NUM_TIMERS);
	localparam int CW = $clog2(NUM_TIMERS + 1);
	// ceil(2^37 / 100): product >> 37 is the exact quotient by 100 for 32-bit values
	localparam logic [31:0] JIT_RECIP = 32'd1374389535;

	logic [3:0]            op_q;
	logic [3:0]            id_q;
	logic [31:0]           val_q;
	logic                  per_q;
	logic [IW-1:0]         t_q;
	logic [CW-1:0]         p_q;
	logic [CW-1:0]         cnt_q;
	logic [5:0]            fires_q;
	logic [31:0]           now_q;
	logic [31:0]           seed_q;
	logic [31:0]           jit_q;
	logic [31:0]           key_q;
	logic [31:0]           acc_q;
	logic [NUM_TIMERS-1:0] alloc_q;
	logic [NUM_TIMERS-1:0] run_q;
	logic [NUM_TIMERS-1:0] cont_q;
	logic [31:0]           ivl_q  [NUM_TIMERS];
	logic [6:0]            jpct_q [NUM_TIMERS];
	logic [31:0]           mj_q   [NUM_TIMERS];
	logic [31:0]           exp_q  [NUM_TIMERS];
	logic [31:0]           fire_q [NUM_TIMERS];
	logic [31:0]           skip_q [NUM_TIMERS];
	logic [IW-1:0]         rank_q [NUM_TIMERS];

	logic                  out_valid_q;
	logic [1:0]            kind_q;
	logic [3:0]            slot_q;
	logic [1:0]            ostat_q;
	logic                  orun_q;
	logic [31:0]           oivl_q;
	logic [31:0]           odue_q;
	logic [31:0]           ofire_q;
	logic [31:0]           oskip_q;
	logic                  olast_q;

	logic                  id_in_range;
	logic [IW-1:0]         rank_p;
	logic [IW-1:0]         xaddr;
	logic [31:0]           x_exp;
	logic [31:0]           now_minus_x;
	logic [31:0]           x_minus_key;
	logic [31:0]           eff;
	logic [31:0]           seed_nx;
	logic                  jit_on;
	logic                  scan_end;
	logic                  scan_hit;
	logic                  ins_stop;
	logic                  q_full;
	logic [31:0]           jiv;
	logic [6:0]            jpct;
	logic                  jsplit;
	logic [31:0]           jmul_a;
	logic [63:0]           jq_prod;
	logic [31:0]           due;
	logic                  emit;
	logic                  div_start;
	logic [31:0]           div_dividend;
	logic [31:0]           div_divisor;
	logic                  div_busy;
	logic [31:0]           div_quot;
	logic [31:0]           div_rem;

	assign id_in_range = int'(id_q) < NUM_TIMERS;
	assign rank_p      = rank_q[p_q[IW-1:0]];

	always_comb begin
		case (cmd.xsel)
			XS_HEAD: xaddr = rank_q[0];
			XS_SCAN: xaddr = rank_p;
			default: xaddr = t_q;
		endcase
	end

	assign x_exp       = exp_q[xaddr];
	assign now_minus_x = now_q - x_exp;
	assign x_minus_key = x_exp - key_q;
	assign eff         = (cont_q[t_q] && ivl_q[t_q] == 32'd0) ? 32'd1 : ivl_q[t_q];
	assign seed_nx     = {seed_q[27:0], 4'b0000} ^ now_q;
	assign jit_on      = (jpct_q[t_q] != 7'd0) && (mj_q[t_q] != 32'd0);
	assign scan_end    = p_q == cnt_q;
	assign scan_hit    = !scan_end && (rank_p == t_q);
	assign ins_stop    = scan_end || (x_minus_key != 32'd0 && !x_minus_key[31]);
	assign q_full      = cnt_q >= CW'(NUM_TIMERS);

	assign jiv     = (op_q == OP_SET_JIT) ? ivl_q[t_q] : val_q;
	assign jpct    = (op_q == OP_SET_JIT) ? val_q[6:0] : jpct_q[t_q];
	assign jsplit  = jiv > SPLIT_LIMIT;
	assign jmul_a  = jsplit ? {7'b0, jiv[31:7]} : jiv;
	assign jq_prod = 64'(acc_q) * 64'(JIT_RECIP);

	assign due  = exp_q[t_q] - now_q;
	assign emit = cmd.op == DP_EMIT;

	always_comb begin
		stat          = '0;
		stat.op       = op_q;
		stat.id_ok    = id_in_range && alloc_q[t_q];
		stat.id_free  = id_in_range && !alloc_q[t_q];
		stat.run      = run_q[t_q];
		stat.cont     = cont_q[t_q];
		stat.val_big  = val_q >= BIG_LIMIT;
		stat.pct_big  = val_q > JIT_PCT_MAX;
		stat.jit_on   = jit_on;
		stat.late_pos = (now_minus_x != 32'd0) && !now_minus_x[31];
		stat.scan_hit = scan_hit;
		stat.scan_end = scan_end;
		stat.ins_stop = ins_stop;
		stat.q_full   = q_full;
		stat.head_due = (cnt_q != '0) && (fires_q != MAX_FIRES) && !now_minus_x[31];
		stat.div_busy = div_busy;
		stat.out_free = !out_valid_q || out_ready;
	end

	always_comb begin
		div_start    = 1'b0;
		div_dividend = now_minus_x;
		div_divisor  = eff;
		case (cmd.op)
			DP_JIT_START: begin
				div_start    = jit_on;
				div_dividend = seed_nx;
				div_divisor  = mj_q[t_q];
			end
			DP_LATE_DIV: begin
				div_start = 1'b1;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	mtes_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_q     <= '0;
			run_q       <= '0;
			cont_q      <= '0;
			cnt_q       <= '0;
			p_q         <= '0;
			fires_q     <= '0;
			now_q       <= '0;
			seed_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				DP_TICK_ADD: begin
					now_q   <= now_q + val_q;
					fires_q <= '0;
				end
				DP_HEAD, DP_RM_START, DP_INS_START: begin
					p_q <= '0;
				end
				DP_RM_STEP: begin
					if (scan_hit) begin
						cnt_q <= cnt_q - 1'b1;
					end else if (!scan_end) begin
						p_q <= p_q + 1'b1;
					end
				end
				DP_INS_STEP: begin
					if (!q_full) begin
						if (ins_stop) begin
							cnt_q <= cnt_q + 1'b1;
						end else begin
							p_q <= p_q + 1'b1;
						end
					end
				end
				DP_JIT_START: begin
					if (jit_on) begin
						seed_q <= seed_nx;
					end
				end
				DP_EXP_NOW: begin
					run_q[t_q] <= 1'b1;
				end
				DP_RUN_CLR: begin
					run_q[t_q] <= 1'b0;
				end
				DP_FIRE: begin
					fires_q <= fires_q + 1'b1;
				end
				DP_CREATE: begin
					alloc_q[t_q] <= 1'b1;
					run_q[t_q]   <= 1'b0;
					cont_q[t_q]  <= per_q;
				end
				DP_CLEAR: begin
					alloc_q[t_q] <= 1'b0;
					run_q[t_q]   <= 1'b0;
					cont_q[t_q]  <= 1'b0;
				end
				default: begin
				end
			endcase
			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LATCH: begin
				op_q  <= in_op;
				id_q  <= in_id;
				val_q <= in_value;
				per_q <= in_periodic;
				t_q   <= IW'(in_id);
			end
			DP_HEAD: begin
				t_q <= rank_q[0];
			end
			DP_RM_STEP: begin
				if (scan_hit) begin
					for (int j = 0; j < NUM_TIMERS - 1; j++) begin
						if (CW'(j) >= p_q && CW'(j + 1) < cnt_q) begin
							rank_q[j] <= rank_q[j + 1];
						end
					end
				end
			end
			DP_INS_START: begin
				key_q <= x_exp;
			end
			DP_INS_STEP: begin
				if (!q_full && ins_stop) begin
					for (int j = 1; j < NUM_TIMERS; j++) begin
						if (CW'(j) > p_q && CW'(j) <= cnt_q) begin
							rank_q[j] <= rank_q[j - 1];
						end
					end
					rank_q[p_q[IW-1:0]] <= t_q;
				end
			end
			DP_JIT_START: begin
				if (!jit_on) begin
					jit_q <= eff;
				end
			end
			DP_JIT_WB: begin
				jit_q <= ivl_q[t_q] - div_rem;
			end
			DP_EXP_NOW: begin
				exp_q[t_q] <= now_q + jit_q;
			end
			DP_EXP_ADD: begin
				exp_q[t_q] <= exp_q[t_q] + jit_q;
			end
			DP_MISS_MUL: begin
				acc_q       <= div_quot * eff;
				skip_q[t_q] <= skip_q[t_q] + div_quot + 32'd1;
			end
			DP_MISS_WB: begin
				exp_q[t_q] <= exp_q[t_q] + acc_q + eff;
			end
			DP_FIRE: begin
				fire_q[t_q] <= fire_q[t_q] + 32'd1;
			end
			DP_CREATE, DP_CLEAR: begin
				ivl_q[t_q]  <= '0;
				jpct_q[t_q] <= '0;
				mj_q[t_q]   <= '0;
				exp_q[t_q]  <= '0;
				fire_q[t_q] <= '0;
				skip_q[t_q] <= '0;
			end
			DP_JMUL: begin
				acc_q <= jmul_a * {25'b0, jpct};
			end
			DP_JDIV: begin
				acc_q <= {5'b0, jq_prod[63:37]};
			end
			DP_JWB: begin
				mj_q[t_q] <= jsplit ? {acc_q[24:0], 7'b0} : acc_q;
				if (op_q == OP_SET_JIT) begin
					jpct_q[t_q] <= val_q[6:0];
				end else begin
					ivl_q[t_q] <= val_q;
				end
			end
			DP_EMIT: begin
				kind_q  <= cmd.kind;
				ostat_q <= cmd.status;
				olast_q <= cmd.last;
				case (cmd.kind)
					KIND_EXPIRY:   slot_q <= 4'(t_q);
					KIND_TICK_END: slot_q <= 4'd0;
					default:       slot_q <= id_q;
				endcase
				if (cmd.full) begin
					orun_q  <= run_q[t_q];
					oivl_q  <= ivl_q[t_q];
					odue_q  <= (run_q[t_q] && !due[31]) ? due : 32'd0;
					ofire_q <= fire_q[t_q];
					oskip_q <= skip_q[t_q];
				end else begin
					orun_q  <= 1'b0;
					oivl_q  <= '0;
					odue_q  <= '0;
					ofire_q <= '0;
					oskip_q <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign out_kind     = kind_q;
	assign out_slot     = slot_q;
	assign out_status   = ostat_q;
	assign out_running  = orun_q;
	assign out_interval = oivl_q;
	assign out_due      = odue_q;
	assign out_invoked  = ofire_q;
	assign out_missed   = oskip_q;
	assign out_last     = olast_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(NUM_TIMERS))
		else $error("queue length beyond timer count");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> (cmd.op != DP_EMIT))
		else $error("stalled result overwritten");

	a_rm_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == DP_RM_STEP && scan_hit) |=> (cnt_q + 1'b1 == $past(cnt_q)))
		else $error("queue removal did not shrink the queue");

endmodule

// ===== sv/mtes_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtes_ctrl
// Sequencer for commands, ticks, queue scans, jitter and missed-interval
// divides, and result beats.
// ----------------------------------------------------------------------------
module mtes_ctrl import mtes_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t st,
	output dp_cmd_t  cmd
);

	state_t     state_q;
	state_t     state_d;
	state_t     after_jit;
	state_t     after_rm;
	state_t     after_ins;
	logic       is_tick;
	logic [1:0] kind_cmd;
	logic [1:0] st_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		is_tick  = st.op == OP_TICK;
		kind_cmd = (st.op == OP_QUERY) ? KIND_QUERY : KIND_DONE;
		if ((st.op == OP_SET || st.op == OP_SET_IVL) && st.val_big) begin
			st_cmd = ST_BIG_IVL;
		end else if (st.op == OP_SET_JIT && st.pct_big) begin
			st_cmd = ST_BIG_JIT;
		end else begin
			st_cmd = ST_OK;
		end

		if (is_tick) begin
			after_jit = S_EXP_ADD;
		end else if (st.run) begin
			after_jit = S_RM_START;
		end else begin
			after_jit = S_EXP_NOW;
		end

		if (is_tick) begin
			after_rm = st.cont ? S_JIT : S_RUN_CLR;
		end else if (st.op == OP_DESTROY) begin
			after_rm = S_CLEAR;
		end else if (st.op == OP_STOP) begin
			after_rm = S_RUN_CLR;
		end else begin
			after_rm = S_EXP_NOW;
		end

		after_ins = is_tick ? S_FIRE : S_EMIT_CMD;

		cmd        = '0;
		cmd.op     = DP_NOP;
		cmd.xsel   = XS_SLOT;
		cmd.kind   = kind_cmd;
		cmd.status = ST_OK;
		cmd.full   = 1'b1;
		cmd.last   = 1'b1;
		in_ready   = 1'b0;
		state_d    = state_q;

		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = DP_LATCH;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				if (is_tick) begin
					cmd.op  = DP_TICK_ADD;
					state_d = S_T_CHK;
				end else if (st.op > OP_QUERY) begin
					state_d = S_IDLE;
				end else if (st.op == OP_CREATE) begin
					if (st.id_free) begin
						cmd.op  = DP_CREATE;
						state_d = S_EMIT_CMD;
					end else begin
						state_d = S_EMIT_BAD;
					end
				end else if (!st.id_ok) begin
					state_d = S_EMIT_BAD;
				end else begin
					case (st.op)
						OP_DESTROY: state_d = st.run ? S_RM_START : S_CLEAR;
						OP_SET, OP_SET_IVL: begin
							if (st.val_big) begin
								state_d = S_EMIT_CMD;
							end else begin
								cmd.op  = DP_JMUL;
								state_d = S_JDIV;
							end
						end
						OP_SET_JIT: begin
							if (st.pct_big) begin
								state_d = S_EMIT_CMD;
							end else begin
								cmd.op  = DP_JMUL;
								state_d = S_JDIV;
							end
						end
						OP_RESTART: state_d = S_JIT;
						OP_STOP:    state_d = st.run ? S_RM_START : S_EMIT_CMD;
						default:    state_d = S_EMIT_CMD;
					endcase
				end
			end
			S_JDIV: begin
				cmd.op  = DP_JDIV;
				state_d = S_JWAIT;
			end
			S_JWAIT: begin
				if (!st.div_busy) begin
					cmd.op = DP_JWB;
					if (st.op == OP_SET && (!st.cont || !st.run)) begin
						state_d = S_JIT;
					end else begin
						state_d = S_EMIT_CMD;
					end
				end
			end
			S_T_CHK: begin
				cmd.xsel = XS_HEAD;
				if (st.head_due) begin
					cmd.op  = DP_HEAD;
					state_d = S_RM;
				end else begin
					state_d = S_EMIT_END;
				end
			end
			S_RM_START: begin
				cmd.op  = DP_RM_START;
				state_d = S_RM;
			end
			S_RM: begin
				cmd.op = DP_RM_STEP;
				if (st.scan_hit || st.scan_end) begin
					state_d = after_rm;
				end
			end
			S_JIT: begin
				cmd.op  = DP_JIT_START;
				state_d = st.jit_on ? S_JIT_WAIT : after_jit;
			end
			S_JIT_WAIT: begin
				if (!st.div_busy) begin
					cmd.op  = DP_JIT_WB;
					state_d = after_jit;
				end
			end
			S_EXP_NOW: begin
				cmd.op  = DP_EXP_NOW;
				state_d = S_INS_START;
			end
			S_EXP_ADD: begin
				cmd.op  = DP_EXP_ADD;
				state_d = S_LATE;
			end
			S_LATE: begin
				if (st.late_pos) begin
					cmd.op  = DP_LATE_DIV;
					state_d = S_LATE_WAIT;
				end else begin
					state_d = S_INS_START;
				end
			end
			S_LATE_WAIT: begin
				if (!st.div_busy) begin
					cmd.op  = DP_MISS_MUL;
					state_d = S_MISS_WB;
				end
			end
			S_MISS_WB: begin
				cmd.op  = DP_MISS_WB;
				state_d = S_INS_START;
			end
			S_INS_START: begin
				cmd.op  = DP_INS_START;
				state_d = S_INS;
			end
			S_INS: begin
				cmd.xsel = XS_SCAN;
				cmd.op   = DP_INS_STEP;
				if (st.q_full || st.ins_stop) begin
					state_d = after_ins;
				end
			end
			S_RUN_CLR: begin
				cmd.op  = DP_RUN_CLR;
				state_d = after_ins;
			end
			S_CLEAR: begin
				cmd.op  = DP_CLEAR;
				state_d = S_EMIT_CMD;
			end
			S_FIRE: begin
				cmd.op  = DP_FIRE;
				state_d = S_EMIT_EXP;
			end
			S_EMIT_CMD: begin
				cmd.status = st_cmd;
				if (st.out_free) begin
					cmd.op  = DP_EMIT;
					state_d = S_IDLE;
				end
			end
			S_EMIT_BAD: begin
				cmd.status = ST_BAD_SLOT;
				cmd.full   = 1'b0;
				if (st.out_free) begin
					cmd.op  = DP_EMIT;
					state_d = S_IDLE;
				end
			end
			S_EMIT_EXP: begin
				cmd.kind = KIND_EXPIRY;
				cmd.last = 1'b0;
				if (st.out_free) begin
					cmd.op  = DP_EMIT;
					state_d = S_T_CHK;
				end
			end
			S_EMIT_END: begin
				cmd.kind = KIND_TICK_END;
				cmd.full = 1'b0;
				if (st.out_free) begin
					cmd.op  = DP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/multi_timer_expiry_scheduler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_timer_expiry_scheduler_unit
// Bank of one-shot and continuous timers with jitter, a sorted expiry queue
// and tick-driven expiry beats.
//
//   channel  dir  beat content
//   s_axis   in   tuser: opcode; tdata: timer_id, value, periodic
//   m_axis   out  tuser: kind; tdata: slot .. missed_count; tlast: last
//   cfg      in   cfg_wdata: jitter_seed_start, loads the seed
//
// A command passes from its accept to its result beat through queue scans
// (remove, insert) and divider passes. On a tick, each fire of a continuous
// timer takes up to two divider passes and an insert scan.
// No clearing pass after reset; one input beat in flight at a time.
// A stalled m_axis holds the sequencer at its next result beat.
// ----------------------------------------------------------------------------
module multi_timer_expiry_scheduler_unit import mtes_pkg::*; #(
	parameter int NUM_TIMERS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [39:0]  s_axis_tdata,  // timer_id, value, periodic
	input  logic [3:0]   s_axis_tuser,  // opcode
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [135:0] m_axis_tdata,  // slot, status, running, interval_ms, due_ms,
	                                    // invoked_count, missed_count
	output logic [1:0]   m_axis_tuser,  // kind
	output logic         m_axis_tlast,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata
);

	dp_cmd_t     cmd;
	dp_stat_t    stat;
	logic [3:0]  slot;
	logic [1:0]  status;
	logic        running;
	logic [31:0] interval_ms;
	logic [31:0] due_ms;
	logic [31:0] invoked_count;
	logic [31:0] missed_count;

	mtes_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (stat),
		.cmd      (cmd)
	);

	mtes_dp #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_op        (s_axis_tuser),
		.in_id        (s_axis_tdata[3:0]),
		.in_value     (s_axis_tdata[35:4]),
		.in_periodic  (s_axis_tdata[36]),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_kind     (m_axis_tuser),
		.out_slot     (slot),
		.out_status   (status),
		.out_running  (running),
		.out_interval (interval_ms),
		.out_due      (due_ms),
		.out_invoked  (invoked_count),
		.out_missed   (missed_count),
		.out_last     (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, missed_count, invoked_count, due_ms, interval_ms,
		running, status, slot};

endmodule
